// ----- hdl/rgfp_pkg.sv -----
package rgfp_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int MAX_IMAGE_DIM = 4096;

    localparam int POS_W   = 13;
    localparam int COLOR_W = 8;
    localparam int THICK_W = 10;
    localparam int DIM_W   = 13;
    localparam int HALF_W  = DIM_W - 1;

    // squared distance dx*dx + dy*dy
    localparam int SQR_W   = 2 * POS_W;
    localparam int DSQ_W   = SQR_W + 1;

    // square root of dsq << (2*FRAC_BITS), one root bit per cell
    localparam int SQ_ROOT_W = (DSQ_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W     = 2 * SQ_ROOT_W;
    localparam int SQ_REM_W  = SQ_ROOT_W + 1;
    localparam int SQ_STEPS  = SQ_ROOT_W;

    // ratio distance / half width, FRAC_BITS+1 quotient bits, one per cell
    localparam int DIV_Q_W   = FRAC_BITS + 1;
    localparam int DIV_STEPS = DIV_Q_W;
    localparam int DVSR_W    = HALF_W + FRAC_BITS;

    localparam logic [DIV_Q_W-1:0] GRAD_ONE = DIV_Q_W'(1 << FRAC_BITS);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_THICKNESS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RED       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLUE      = 3'd5;

    localparam int S_DATA_W = ((2 * POS_W + 3 * COLOR_W + 7) / 8) * 8;
    localparam int M_DATA_W = 3 * COLOR_W;

    typedef struct packed {
        logic               border;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]     rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [SQ_ROOT_W-1:0] rem;
        logic [DVSR_W-1:0]    dvsr;
        logic [DIV_Q_W-1:0]   quo;
    } dv_t;

endpackage

// ----- hdl/rgfp_front.sv -----
module rgfp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgfp_pkg::POS_W-1:0]    pos_x,
    input  logic [rgfp_pkg::POS_W-1:0]    pos_y,
    input  logic [rgfp_pkg::COLOR_W-1:0]  src_red,
    input  logic [rgfp_pkg::COLOR_W-1:0]  src_green,
    input  logic [rgfp_pkg::COLOR_W-1:0]  src_blue,
    input  logic [rgfp_pkg::THICK_W-1:0]  border_thickness,
    input  logic [rgfp_pkg::DIM_W-1:0]    image_width,
    input  logic [rgfp_pkg::DIM_W-1:0]    image_height,
    output logic [rgfp_pkg::HALF_W-1:0]   half_w,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rgfp_pkg::DSQ_W-1:0]    dsq,
    output rgfp_pkg::side_t               out_side
);

    localparam int PW = rgfp_pkg::POS_W;
    localparam int DW = rgfp_pkg::DIM_W;

    logic [DW-1:0] w_sat, h_sat, fw, fh, w_end, h_end;
    logic [rgfp_pkg::HALF_W-1:0] half_h;
    logic [PW-1:0] dx_next, dy_next;
    logic border;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [PW-1:0] dx_reg, dy_reg;
    logic [rgfp_pkg::SQR_W-1:0] sqx_reg, sqy_reg;
    logic [rgfp_pkg::DSQ_W-1:0] dsq_reg;
    rgfp_pkg::side_t side1_reg, side2_reg, side3_reg;

    always_comb
    begin
        w_sat = (image_width > DW'(rgfp_pkg::MAX_IMAGE_DIM)) ?
                DW'(rgfp_pkg::MAX_IMAGE_DIM) : image_width;
        h_sat = (image_height > DW'(rgfp_pkg::MAX_IMAGE_DIM)) ?
                DW'(rgfp_pkg::MAX_IMAGE_DIM) : image_height;
        fw     = w_sat + {2'b00, border_thickness, 1'b0};
        fh     = h_sat + {2'b00, border_thickness, 1'b0};
        w_end  = w_sat + {3'b000, border_thickness};
        h_end  = h_sat + {3'b000, border_thickness};
        half_w = fw[DW-1:1];
        half_h = fh[DW-1:1];
        border = (pos_x < {3'b000, border_thickness}) || (pos_x >= w_end) ||
                 (pos_y < {3'b000, border_thickness}) || (pos_y >= h_end);
        dx_next = (pos_x >= {1'b0, half_w}) ? pos_x - {1'b0, half_w}
                                            : {1'b0, half_w} - pos_x;
        dy_next = (pos_y >= {1'b0, half_h}) ? pos_y - {1'b0, half_h}
                                            : {1'b0, half_h} - pos_y;
    end

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side1_reg <= '{border: border, red: src_red, green: src_green, blue: src_blue};
        end
        if (rdy2 && v1_reg)
        begin
            sqx_reg   <= dx_reg * dx_reg;
            sqy_reg   <= dy_reg * dy_reg;
            side2_reg <= side1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            dsq_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign dsq       = dsq_reg;
    assign out_side  = side3_reg;

endmodule

// ----- hdl/rgfp_sqrt_cell.sv -----
module rgfp_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rgfp_pkg::sq_t   in_sq,
    input  rgfp_pkg::side_t in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output rgfp_pkg::sq_t   out_sq,
    output rgfp_pkg::side_t out_side
);

    localparam int ACC_W = rgfp_pkg::SQ_REM_W + 2;

    logic [ACC_W-1:0] acc, trial, diff;
    logic             take;
    logic             valid_reg;
    rgfp_pkg::sq_t    sq_reg, sq_next;
    rgfp_pkg::side_t  side_reg;

    // bring down the next two radicand bits, try root*4+1
    always_comb
    begin
        acc   = {in_sq.rem, in_sq.rad[rgfp_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, in_sq.root, 2'b01};
        diff  = acc - trial;
        take  = (acc >= trial);
        sq_next.rad  = in_sq.rad << 2;
        sq_next.rem  = take ? diff[rgfp_pkg::SQ_REM_W-1:0] : acc[rgfp_pkg::SQ_REM_W-1:0];
        sq_next.root = {in_sq.root[rgfp_pkg::SQ_ROOT_W-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

// ----- hdl/rgfp_div_cell.sv -----
module rgfp_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rgfp_pkg::dv_t   in_dv,
    input  rgfp_pkg::side_t in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output rgfp_pkg::dv_t   out_dv,
    output rgfp_pkg::side_t out_side
);

    localparam int RW = rgfp_pkg::SQ_ROOT_W;

    logic [RW-1:0]   dvsr_ext;
    logic            take;
    logic            valid_reg;
    rgfp_pkg::dv_t   dv_reg, dv_next;
    rgfp_pkg::side_t side_reg;

    // restoring step; an oversized dividend just sets every remaining bit
    always_comb
    begin
        dvsr_ext     = RW'(in_dv.dvsr);
        take         = (in_dv.rem >= dvsr_ext);
        dv_next.rem  = take ? in_dv.rem - dvsr_ext : in_dv.rem;
        dv_next.dvsr = in_dv.dvsr >> 1;
        dv_next.quo  = {in_dv.quo[rgfp_pkg::DIV_Q_W-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dv_reg   <= dv_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_dv    = dv_reg;
    assign out_side  = side_reg;

endmodule

// ----- hdl/rgfp_shade.sv -----
module rgfp_shade (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rgfp_pkg::DIV_Q_W-1:0]    quo,
    input  rgfp_pkg::side_t                 in_side,
    input  logic [rgfp_pkg::COLOR_W-1:0]    frame_red,
    input  logic [rgfp_pkg::COLOR_W-1:0]    frame_green,
    input  logic [rgfp_pkg::COLOR_W-1:0]    frame_blue,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rgfp_pkg::M_DATA_W-1:0]   out_data,
    output logic                            out_border
);

    localparam int CW = rgfp_pkg::COLOR_W;
    localparam int QW = rgfp_pkg::DIV_Q_W;
    localparam int PW = CW + QW;

    logic [QW-1:0] grad;
    logic [PW-1:0] prod_r, prod_g, prod_b;
    logic [CW-1:0] red_next, green_next, blue_next;
    logic          valid_reg;
    logic [rgfp_pkg::M_DATA_W-1:0] data_reg;
    logic          border_reg;

    always_comb
    begin
        // past the gradient radius (or zero half width) the frame goes black
        grad       = (quo > rgfp_pkg::GRAD_ONE) ? '0 : rgfp_pkg::GRAD_ONE - quo;
        prod_r     = PW'(frame_red) * PW'(grad);
        prod_g     = PW'(frame_green) * PW'(grad);
        prod_b     = PW'(frame_blue) * PW'(grad);
        red_next   = in_side.border ? prod_r[rgfp_pkg::FRAC_BITS +: CW] : in_side.red;
        green_next = in_side.border ? prod_g[rgfp_pkg::FRAC_BITS +: CW] : in_side.green;
        blue_next  = in_side.border ? prod_b[rgfp_pkg::FRAC_BITS +: CW] : in_side.blue;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg   <= {blue_next, green_next, red_next};
            border_reg <= in_side.border;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_border = border_reg;

endmodule

// ----- hdl/radial_gradient_frame_pixel_core.sv -----
// Radial gradient frame, one pixel per request.
// Input stream: one request per output pixel of the framed image, carrying
// its column and row and the source RGB pixel at the shifted position.
// Output stream: the pixel color; tuser is high when the pixel lies on the
// border and carries the frame color scaled by the radial gradient.
// Configuration (thickness, image size, frame color) is written through
// cfg_we/cfg_addr/cfg_wdata; the user writes it only while no request is in
// flight, as the block itself does not enforce this. Throughput: one pixel
// per clock while m_tready is high, set by the row of cells: 3 front stages
// (border test, squares, sum), 22 square-root cells, 9 divider cells and
// the output register. Every stage holds when its successor is full, so
// bubbles close up and a new request is taken while a result waits in the
// output register. When m_tready stays low the chain fills and s_tready
// drops after 35 requests. Reset empties the pipeline and loads
// thickness 0, image size 1 x 1 and a white frame color.
module radial_gradient_frame_pixel_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[12:0], pos_y[25:13], src_red[33:26], src_green[41:34],
    // src_blue[49:42], zero fill above
    input  logic [rgfp_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [rgfp_pkg::M_DATA_W-1:0]      m_tdata,
    // on_border[0]
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [rgfp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rgfp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int PW = rgfp_pkg::POS_W;
    localparam int CW = rgfp_pkg::COLOR_W;
    localparam int NS = rgfp_pkg::SQ_STEPS;
    localparam int ND = rgfp_pkg::DIV_STEPS;

    logic [rgfp_pkg::THICK_W-1:0] thick_reg;
    logic [rgfp_pkg::DIM_W-1:0]   width_reg, height_reg;
    logic [CW-1:0]                red_reg, green_reg, blue_reg;

    logic [rgfp_pkg::HALF_W-1:0]  half_w;
    logic [rgfp_pkg::DSQ_W-1:0]   dsq;

    rgfp_pkg::sq_t   sq_bus   [0:NS];
    rgfp_pkg::side_t sq_side  [0:NS];
    logic            sq_valid [0:NS];
    logic            sq_ready [0:NS];

    rgfp_pkg::dv_t   dv_bus   [0:ND];
    rgfp_pkg::side_t dv_side  [0:ND];
    logic            dv_valid [0:ND];
    logic            dv_ready [0:ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thick_reg  <= '0;
            width_reg  <= rgfp_pkg::DIM_W'(1);
            height_reg <= rgfp_pkg::DIM_W'(1);
            red_reg    <= '1;
            green_reg  <= '1;
            blue_reg   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rgfp_pkg::CFG_THICKNESS: thick_reg  <= cfg_wdata[rgfp_pkg::THICK_W-1:0];
                rgfp_pkg::CFG_WIDTH:     width_reg  <= cfg_wdata[rgfp_pkg::DIM_W-1:0];
                rgfp_pkg::CFG_HEIGHT:    height_reg <= cfg_wdata[rgfp_pkg::DIM_W-1:0];
                rgfp_pkg::CFG_RED:       red_reg    <= cfg_wdata[CW-1:0];
                rgfp_pkg::CFG_GREEN:     green_reg  <= cfg_wdata[CW-1:0];
                rgfp_pkg::CFG_BLUE:      blue_reg   <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    rgfp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .pos_x            (s_tdata[PW-1:0]),
        .pos_y            (s_tdata[2*PW-1:PW]),
        .src_red          (s_tdata[2*PW +: CW]),
        .src_green        (s_tdata[2*PW+CW +: CW]),
        .src_blue         (s_tdata[2*PW+2*CW +: CW]),
        .border_thickness (thick_reg),
        .image_width      (width_reg),
        .image_height     (height_reg),
        .half_w           (half_w),
        .out_valid        (sq_valid[0]),
        .out_ready        (sq_ready[0]),
        .dsq              (dsq),
        .out_side         (sq_side[0])
    );

    // radicand is the squared distance scaled by 2^(2*FRAC_BITS)
    assign sq_bus[0] = '{
        rad:  {{(rgfp_pkg::RAD_W - rgfp_pkg::DSQ_W - 2*rgfp_pkg::FRAC_BITS){1'b0}},
               dsq, {(2*rgfp_pkg::FRAC_BITS){1'b0}}},
        rem:  '0,
        root: '0
    };

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        rgfp_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_sq     (sq_bus[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_sq    (sq_bus[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    assign dv_bus[0]   = '{rem: sq_bus[NS].root,
                           dvsr: {half_w, {rgfp_pkg::FRAC_BITS{1'b0}}},
                           quo: '0};
    assign dv_side[0]  = sq_side[NS];
    assign dv_valid[0] = sq_valid[NS];
    assign sq_ready[NS] = dv_ready[0];

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        rgfp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_dv     (dv_bus[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_dv    (dv_bus[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    rgfp_shade u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (dv_valid[ND]),
        .in_ready    (dv_ready[ND]),
        .quo         (dv_bus[ND].quo),
        .in_side     (dv_side[ND]),
        .frame_red   (red_reg),
        .frame_green (green_reg),
        .frame_blue  (blue_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_border  (m_tuser)
    );

endmodule
